// ----- src/grfc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the gauge reply frame checker.
// No dependencies; imported by gauge_reply_frame_checker_top.
package grfc_pkg;

    localparam int CAPTURE_BYTES = 24;
    localparam int CAP_IDX_W     = $clog2(CAPTURE_BYTES);

    localparam logic [7:0]  FRAME_MIN   = 8'd3;
    localparam logic [7:0]  FRAME_FULL  = 8'd25;
    localparam logic [7:0]  COUNT_MAX   = 8'd255;
    localparam logic [7:0]  SUM_START   = 8'd2;

    localparam logic [31:0] SENTINEL_A  = 32'h7FA0_0000;
    localparam logic [31:0] SENTINEL_B  = 32'hFFFF_FF00;
    localparam logic [31:0] TINY_BITS   = 32'h3727_C5AC;  // 0.00001f

    localparam logic REG_UNIT_ADDRESS = 1'b0;
    localparam logic REG_ERROR_LIMIT  = 1'b1;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        OUTCOME_OK       = 2'd0,
        OUTCOME_CHECKSUM = 2'd1,
        OUTCOME_FIELD    = 2'd2,
        OUTCOME_TIMEOUT  = 2'd3
    } outcome_t;

    // First member lands in the top bits of the packed word.
    typedef struct packed {
        logic        alarm;
        logic [7:0]  error_count;
        logic [15:0] gauge_status;
        logic [31:0] water_level_bits;
        logic [31:0] density_bits;
        logic [31:0] temperature_bits;
        logic [31:0] product_level_bits;
        outcome_t    outcome;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Fixed byte expected at a frame position; has is low where none applies.
    function automatic logic [8:0] fixed_byte(input logic [7:0] pos);
        logic [8:0] r;
        case (pos)
            8'd0:    r = {1'b1, 8'hB5};
            8'd2:    r = {1'b1, 8'h14};
            8'd4:    r = {1'b1, 8'h01};
            8'd8:    r = {1'b1, 8'h02};
            8'd12:   r = {1'b1, 8'h06};
            8'd16:   r = {1'b1, 8'h08};
            8'd20:   r = {1'b1, 8'hF0};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] value_bits(input logic [7:0] b0,
                                               input logic [7:0] b1,
                                               input logic [7:0] b2);
        logic [31:0] v;
        v = {b2, b1, b0, 8'h00};
        if (v == SENTINEL_A || v == SENTINEL_B)
        begin
            v = TINY_BITS;
        end
        return v;
    endfunction

endpackage

// ----- src/gauge_reply_frame_checker_top.sv -----
`timescale 1ns / 1ps
// Gauge reply frame checker: byte accumulation, frame check and result register.
// Depends on grfc_pkg.
//
// Usage:
//   s_* carries one request per byte: s_tdata[7:0] is the received byte,
//   s_tuser is 0 for a byte and 1 for the reply-gap timeout that ends a frame.
//   Each timeout request produces one result on m_*; byte requests produce none.
//   m_tdata (160 bits) packs outcome, four float patterns, gauge status,
//   error count and alarm. cfg_we/cfg_index/cfg_wdata write unit_address (0)
//   and error_limit (1); write only while no result is pending.
//   Throughput: one request per cycle while the output is not stalled. Frame state
//   updates in the accepting cycle; the result is registered and shows on m_* in the
//   cycle after the timeout request is accepted.
//   If the receiver stalls, the result holds in the output register and
//   s_tready drops until it is taken; a result taken in the same cycle lets
//   the next request in without a bubble.
//   Reset (rst_n low, async) clears frame state, the failure count, the
//   pending result and the registers back to unit_address 1, error_limit 3.
//   Captured payload bytes are not reset; they are always rewritten before use.
module gauge_reply_frame_checker_top
    import grfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // slave side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    input  logic                s_tuser,   // [0] cmd
    // master side
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [1:0] outcome, [33:2] product_level_bits,
                                           // [65:34] temperature_bits, [97:66] density_bits,
                                           // [129:98] water_level_bits, [145:130] gauge_status,
                                           // [153:146] error_count, [154] alarm, rest zero
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_wdata
);

    logic [7:0] unit_address_reg;
    logic [7:0] error_limit_reg;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] last_byte_reg, last_byte_next;
    logic       field_mismatch_reg, field_mismatch_next;
    logic [7:0] fail_count_reg, fail_count_next;
    logic [7:0] payload_reg [CAPTURE_BYTES];

    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg, out_data_next;

    logic       accept;
    logic       accept_byte;
    logic       accept_end;
    logic [8:0] want;
    logic [7:0] fail_inc;
    outcome_t   outcome;

    assign s_tready    = !out_valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign accept_byte = accept && (s_tuser == CMD_BYTE);
    assign accept_end  = accept && (s_tuser == CMD_TIMEOUT);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RESULT_W){1'b0}}, out_data_reg};

    assign want = fixed_byte(byte_count_reg);

    // frame classification from the accumulated state
    always_comb
    begin
        if (byte_count_reg < FRAME_MIN)
        begin
            outcome = OUTCOME_TIMEOUT;
        end
        else if (running_sum_reg != last_byte_reg)
        begin
            outcome = OUTCOME_CHECKSUM;
        end
        else if (byte_count_reg < FRAME_FULL || field_mismatch_reg
                 || payload_reg[1] != unit_address_reg)
        begin
            outcome = OUTCOME_FIELD;
        end
        else
        begin
            outcome = OUTCOME_OK;
        end
    end

    assign fail_inc = (fail_count_reg != COUNT_MAX) ? fail_count_reg + 8'd1 : fail_count_reg;

    always_comb
    begin
        byte_count_next     = byte_count_reg;
        running_sum_next    = running_sum_reg;
        last_byte_next      = last_byte_reg;
        field_mismatch_next = field_mismatch_reg;
        fail_count_next     = fail_count_reg;
        out_data_next       = out_data_reg;
        out_valid_next      = out_valid_reg && !m_tready;

        if (accept_byte)
        begin
            if (want[8] && s_tdata != want[7:0])
            begin
                field_mismatch_next = 1'b1;
            end
            // sum covers bytes 1..n-2: add the previous byte once two are in
            if (byte_count_reg >= SUM_START)
            begin
                running_sum_next = running_sum_reg + last_byte_reg;
            end
            last_byte_next = s_tdata;
            if (byte_count_reg != COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + 8'd1;
            end
        end
        else if (accept_end)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next.outcome = outcome;
            if (outcome == OUTCOME_OK)
            begin
                out_data_next.product_level_bits =
                    value_bits(payload_reg[5], payload_reg[6], payload_reg[7]);
                out_data_next.temperature_bits =
                    value_bits(payload_reg[9], payload_reg[10], payload_reg[11]);
                out_data_next.density_bits =
                    value_bits(payload_reg[13], payload_reg[14], payload_reg[15]);
                out_data_next.water_level_bits =
                    value_bits(payload_reg[17], payload_reg[18], payload_reg[19]);
                out_data_next.gauge_status = {payload_reg[22], payload_reg[21]};
                fail_count_next = 8'd0;
            end
            else if (fail_inc >= error_limit_reg)
            begin
                fail_count_next      = error_limit_reg;
                out_data_next.alarm  = 1'b1;
            end
            else
            begin
                fail_count_next = fail_inc;
            end
            out_data_next.error_count = fail_count_next;

            byte_count_next     = 8'd0;
            running_sum_next    = 8'd0;
            last_byte_next      = 8'd0;
            field_mismatch_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_address_reg   <= 8'd1;
            error_limit_reg    <= 8'd3;
            byte_count_reg     <= 8'd0;
            running_sum_reg    <= 8'd0;
            last_byte_reg      <= 8'd0;
            field_mismatch_reg <= 1'b0;
            fail_count_reg     <= 8'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UNIT_ADDRESS: unit_address_reg <= cfg_wdata;
                    REG_ERROR_LIMIT:  error_limit_reg  <= cfg_wdata;
                    default:          ;
                endcase
            end
            byte_count_reg     <= byte_count_next;
            running_sum_reg    <= running_sum_next;
            last_byte_reg      <= last_byte_next;
            field_mismatch_reg <= field_mismatch_next;
            fail_count_reg     <= fail_count_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload capture and result data, no reset
    always_ff @(posedge clk)
    begin
        if (accept_byte && byte_count_reg < CAPTURE_BYTES[7:0])
        begin
            payload_reg[byte_count_reg[CAP_IDX_W-1:0]] <= s_tdata;
        end
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept_end |=> m_tvalid && byte_count_reg == 8'd0 && !field_mismatch_reg)
        else $error("frame end did not produce a result or clear frame state");

    a_ok_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_data_reg.outcome == OUTCOME_OK
        |-> out_data_reg.error_count == 8'd0 && !out_data_reg.alarm)
        else $error("successful frame left a failure count or alarm");

    a_alarm_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_data_reg.alarm |-> out_data_reg.error_count == error_limit_reg
        && fail_count_reg == error_limit_reg)
        else $error("alarm raised with count not at the limit");

    a_fail_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept_end && outcome != OUTCOME_OK && fail_count_reg < error_limit_reg
        |=> fail_count_reg <= error_limit_reg)
        else $error("failure count passed the limit");
`endif

endmodule
